>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// The using scope must provide clk and rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

>>> rtl/trp_pkg.sv
// ---------------------------------------------------------------------------
// trp_pkg
// Shared types, character codes and helpers of the terminal reply parser.
// ---------------------------------------------------------------------------
package trp_pkg;

  localparam int MAX_PARAMS_DEF = 2;

  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 16;
  localparam int VALUE_W = 16;
  localparam int KIND_W  = 2;

  // Raw byte codes
  localparam logic [BYTE_W-1:0] CH_SUB = 8'd26;

  // Decoded character codes
  localparam logic [CHAR_W-1:0] CH_ESC      = 16'd27;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 16'h005B;
  localparam logic [CHAR_W-1:0] CH_LBRACE   = 16'h007B;
  localparam logic [CHAR_W-1:0] CH_FINAL_R  = 16'h0052;
  localparam logic [CHAR_W-1:0] CH_FINAL_I  = 16'h0069;
  localparam logic [CHAR_W-1:0] CH_SEMI     = 16'h003B;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE     = 16'h0039;

  localparam logic [VALUE_W-1:0] VALUE_SAT = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_SIZE   = 2'd2,
    KIND_FAIL   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_SCAN   = 2'd0,
    PH_ESC    = 2'd1,
    PH_PARAMS = 2'd2
  } parse_phase_t;

  typedef enum logic [1:0] {
    WIDE_NONE = 2'd0,
    WIDE_LOW  = 2'd1,
    WIDE_HIGH = 2'd2
  } wide_phase_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] value;
  } char_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [CHAR_W-1:0]  char_value;
    logic [VALUE_W-1:0] value_a;
    logic [VALUE_W-1:0] value_b;
  } result_t;

  // acc * 10 + digit, clamped to the parameter range
  function automatic logic [VALUE_W-1:0] acc_digit(input logic [VALUE_W-1:0] acc,
                                                   input logic [3:0] digit);
    logic [VALUE_W+3:0] wide;
    wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VALUE_W{1'b0}}, digit};
    if (wide > {4'd0, VALUE_SAT}) begin
      acc_digit = VALUE_SAT;
    end else begin
      acc_digit = wide[VALUE_W-1:0];
    end
  endfunction

endpackage

>>> rtl/terminal_reply_parser_top.sv
// ---------------------------------------------------------------------------
// terminal_reply_parser_top
// Terminal input byte parser: characters and escape replies to results.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one terminal byte per transaction in s_tdata[7:0].
//   Output stream m_*: at most one result per byte; m_tuser carries the kind
//   (pass-through character, cursor report, size report, failure) and
//   m_tdata carries the character and the two report values.
//   Bytes that complete no result (SUB prefix, low byte of a wide char,
//   ESC, introducer, digits, separators) produce no output transaction.
// Path: a byte is registered at the input, decoded by the character
//   assembler and the reply state machine combinationally, and its result
//   is registered at the output, which drives m_tvalid.
// Throughput: one byte per cycle while the output register is not held
//   by a low m_tready with a result pending.
// Stalls: while m_tready is low with a result pending, the input register
//   holds one more byte and then s_tready drops.
// Reset: rst (synchronous) empties both registers and returns the parser to
//   scanning with no wide character pending and parameters cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module terminal_reply_parser_top #(
  parameter int MAX_PARAMS = trp_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] char_value, [31:16] value_a, [47:32] value_b
  output logic [1:0]  m_tuser    // [1:0] kind
);

  logic                       advance;
  logic                       held_valid;
  logic [trp_pkg::BYTE_W-1:0] held_byte;
  logic                       fire;
  trp_pkg::char_t             char_w;
  trp_pkg::result_t           res;

  logic                        out_valid;
  trp_pkg::kind_t              out_kind;
  logic [trp_pkg::CHAR_W-1:0]  out_char;
  logic [trp_pkg::VALUE_W-1:0] out_a, out_b;

  // the output register is free when empty or being taken
  assign advance = !out_valid || m_tready;
  assign fire    = held_valid && advance;

  trp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .take       (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  trp_wide_char u_wide_char (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .in_byte  (held_byte),
    .char_out (char_w)
  );

  trp_reply_parser #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_reply_parser (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_w),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind <= res.kind;
      out_char <= res.char_value;
      out_a    <= res.value_a;
      out_b    <= res.value_b;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {out_b, out_a, out_char};

  `ASSERT_ALWAYS(a_report_no_char, (m_tvalid && m_tuser != trp_pkg::KIND_CHAR) |-> (m_tdata[15:0] == '0), "report or failure carries a character")
  `ASSERT_ALWAYS(a_plain_no_values, (m_tvalid && (m_tuser == trp_pkg::KIND_CHAR || m_tuser == trp_pkg::KIND_FAIL)) |-> (m_tdata[47:16] == '0), "character or failure carries values")
  `ASSERT_NEXT(a_held_byte_kept, held_valid && !advance, held_valid && $stable(held_byte), "input register lost a byte")

endmodule

>>> rtl/trp_in_stage.sv
// ---------------------------------------------------------------------------
// trp_in_stage
// Input register: holds one received byte until the parser takes it.
// ---------------------------------------------------------------------------
module trp_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [trp_pkg::BYTE_W-1:0] in_byte,
  input  logic                       take,
  output logic                       held_valid,
  output logic [trp_pkg::BYTE_W-1:0] held_byte
);

  logic                       valid_q;
  logic [trp_pkg::BYTE_W-1:0] byte_q;

  assign in_ready   = !valid_q || take;
  assign held_valid = valid_q;
  assign held_byte  = byte_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
  end

endmodule

>>> rtl/trp_wide_char.sv
// ---------------------------------------------------------------------------
// trp_wide_char
// Character assembly: a SUB byte joins the next two bytes, low byte first.
// ---------------------------------------------------------------------------
module trp_wide_char (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [trp_pkg::BYTE_W-1:0] in_byte,
  output trp_pkg::char_t             char_out
);

  trp_pkg::wide_phase_t       phase, phase_next;
  logic [trp_pkg::BYTE_W-1:0] low_byte, low_byte_next;

  always_comb begin
    phase_next    = phase;
    low_byte_next = low_byte;
    case (phase)
      trp_pkg::WIDE_LOW: begin
        low_byte_next = in_byte;
        phase_next    = trp_pkg::WIDE_HIGH;
      end
      trp_pkg::WIDE_HIGH: begin
        phase_next = trp_pkg::WIDE_NONE;
      end
      default: begin
        phase_next = (in_byte == trp_pkg::CH_SUB) ? trp_pkg::WIDE_LOW : trp_pkg::WIDE_NONE;
      end
    endcase
  end

  always_comb begin
    case (phase)
      trp_pkg::WIDE_LOW: begin
        char_out.valid = 1'b0;
        char_out.value = '0;
      end
      trp_pkg::WIDE_HIGH: begin
        char_out.valid = fire;
        char_out.value = {in_byte, low_byte};
      end
      default: begin
        char_out.valid = fire && (in_byte != trp_pkg::CH_SUB);
        char_out.value = {{(trp_pkg::CHAR_W-trp_pkg::BYTE_W){1'b0}}, in_byte};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= trp_pkg::WIDE_NONE;
      low_byte <= '0;
    end else if (fire) begin
      phase    <= phase_next;
      low_byte <= low_byte_next;
    end
  end

endmodule

>>> rtl/trp_reply_parser.sv
// ---------------------------------------------------------------------------
// trp_reply_parser
// Escape reply state machine with decimal parameter accumulators.
// ---------------------------------------------------------------------------
module trp_reply_parser #(
  parameter int MAX_PARAMS = trp_pkg::MAX_PARAMS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  trp_pkg::char_t   char_in,
  output trp_pkg::result_t result
);

  localparam int IDX_W = $clog2(MAX_PARAMS + 2);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PARAMS);
  localparam logic [IDX_W-1:0] IDX_SAT  = IDX_W'(MAX_PARAMS + 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  trp_pkg::parse_phase_t       phase, phase_next;
  logic                        brace, brace_next;
  logic [trp_pkg::VALUE_W-1:0] p0, p0_next, p1, p1_next;
  logic [IDX_W-1:0]            idx, idx_next, idx_eff;
  logic [trp_pkg::CHAR_W-1:0]  c;
  logic                        is_digit;

  assign c        = char_in.value;
  assign is_digit = (c >= trp_pkg::CH_ZERO) && (c <= trp_pkg::CH_NINE);
  assign idx_eff  = (idx == '0) ? IDX_ONE : idx;

  always_comb begin
    phase_next = phase;
    brace_next = brace;
    p0_next    = p0;
    p1_next    = p1;
    idx_next   = idx;
    case (phase)
      trp_pkg::PH_ESC: begin
        if (c == trp_pkg::CH_LBRACKET || c == trp_pkg::CH_LBRACE) begin
          brace_next = (c == trp_pkg::CH_LBRACE);
          p0_next    = '0;
          p1_next    = '0;
          idx_next   = '0;
          phase_next = trp_pkg::PH_PARAMS;
        end else begin
          phase_next = trp_pkg::PH_SCAN;
        end
      end
      trp_pkg::PH_PARAMS: begin
        if (is_digit) begin
          idx_next = idx_eff;
          // digits past the stored count are dropped
          if (idx_eff <= IDX_LAST) begin
            if (idx_eff == IDX_ONE) begin
              p0_next = trp_pkg::acc_digit(p0, c[3:0]);
            end else begin
              p1_next = trp_pkg::acc_digit(p1, c[3:0]);
            end
          end
        end else if (c == trp_pkg::CH_SEMI) begin
          if (idx < IDX_SAT) begin
            idx_next = idx + IDX_ONE;
          end
        end else begin
          phase_next = trp_pkg::PH_SCAN;
          p0_next    = '0;
          p1_next    = '0;
          idx_next   = '0;
        end
      end
      default: begin
        phase_next = (c == trp_pkg::CH_ESC) ? trp_pkg::PH_ESC : trp_pkg::PH_SCAN;
      end
    endcase
  end

  always_comb begin
    result.valid      = 1'b0;
    result.kind       = trp_pkg::KIND_CHAR;
    result.char_value = '0;
    result.value_a    = '0;
    result.value_b    = '0;
    case (phase)
      trp_pkg::PH_ESC: begin
        if (!(c == trp_pkg::CH_LBRACKET || c == trp_pkg::CH_LBRACE)) begin
          result.valid = char_in.valid;
          result.kind  = trp_pkg::KIND_FAIL;
        end
      end
      trp_pkg::PH_PARAMS: begin
        if (!is_digit && c != trp_pkg::CH_SEMI) begin
          result.valid = char_in.valid;
          if (!brace && c == trp_pkg::CH_FINAL_R) begin
            result.kind    = trp_pkg::KIND_CURSOR;
            result.value_a = p1;
            result.value_b = p0;
          end else if (brace && c == trp_pkg::CH_FINAL_I) begin
            result.kind    = trp_pkg::KIND_SIZE;
            result.value_a = p0;
            result.value_b = p1;
          end else begin
            result.kind = trp_pkg::KIND_FAIL;
          end
        end
      end
      default: begin
        if (c != trp_pkg::CH_ESC) begin
          result.valid      = char_in.valid;
          result.char_value = c;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= trp_pkg::PH_SCAN;
      brace <= 1'b0;
      p0    <= '0;
      p1    <= '0;
      idx   <= '0;
    end else if (char_in.valid) begin
      phase <= phase_next;
      brace <= brace_next;
      p0    <= p0_next;
      p1    <= p1_next;
      idx   <= idx_next;
    end
  end

endmodule
